// ===== hw/rtl/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp_pkg
// shared constants, types and modular helpers for the matrix power block
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int MAX_DIM     = 64;
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_LIMIT   = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int VAL_W       = 16;
  localparam int OP_W        = 2;
  localparam int FIELD_IDX_W = 6;
  localparam int DIM_W       = 7;
  localparam int EXP_W       = 63;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 63;
  localparam int RAM_DEPTH   = 3 * MAX_DIM;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int DRAIN_W     = 2;

  localparam logic [VAL_W:0]     MODULUS    = 17'd65521;
  // 2^16 mod 65521
  localparam logic [3:0]         FOLD       = 4'd15;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

  typedef logic [FIELD_IDX_W:0] fidx_wide_t;
  typedef logic [RAM_AW+1:0]    ram_wide_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_VEC = 2'd0,
    OP_LOAD_MAT = 2'd1,
    OP_START    = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMENSION = 2'd0,
    CFG_EXPONENT  = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BANK_STORE = 2'd0,
    BANK_A     = 2'd1,
    BANK_B     = 2'd2
  } bank_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             load_vec;
    logic             load_mat;
    idx_t             ld_row;
    idx_t             ld_col;
    logic [VAL_W-1:0] ld_value;
    logic             init_vec;
    bank_t            rd_bank;
    logic             rd_own;
    idx_t             row;
    logic             set_k;
    logic             step_k;
    logic             load_sh;
    logic             sh_from_vec;
    logic             rotate;
    logic             mac_v;
    logic             clr_acc;
    logic             wr_vec;
    logic             wr_res;
    bank_t            wr_bank;
    idx_t             d_last;
    logic             shift_out;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    idx_t idx;
    logic last;
  } out_stat_t;

  function automatic logic [RAM_AW-1:0] ram_addr(bank_t b, idx_t row);
    ram_wide_t a;
    a = ram_wide_t'(b) * ram_wide_t'(MAX_DIM) + ram_wide_t'(row);
    return a[RAM_AW-1:0];
  endfunction

  // one conditional subtract, valid for inputs below twice the modulus
  function automatic logic [VAL_W-1:0] reduce_once(logic [VAL_W:0] x);
    logic [VAL_W:0] y;
    y = x - MODULUS;
    return (x >= MODULUS) ? y[VAL_W-1:0] : x[VAL_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/mmp_if.sv =====
// ----------------------------------------------------------------------------
// mmp_if
// valid/ready channels of the matrix power block
// ----------------------------------------------------------------------------
interface mmp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mmp_pkg::OP_W-1:0]              opcode;
  logic [mmp_pkg::FIELD_IDX_W-1:0]       row_index;
  logic [mmp_pkg::FIELD_IDX_W-1:0]       col_index;
  logic [mmp_pkg::VAL_W-1:0]             value;
  modport source (output valid, opcode, row_index, col_index, value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, value, output ready);
endinterface

interface mmp_out_if;
  logic                            valid;
  logic                            ready;
  logic [mmp_pkg::FIELD_IDX_W-1:0] result_index;
  logic [mmp_pkg::VAL_W-1:0]       result_value;
  logic                            last;
  modport source (output valid, result_index, result_value, last, input ready);
  modport sink   (input valid, result_index, result_value, last, output ready);
endinterface

interface mmp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mmp_pkg::CFG_IDX_W-1:0]  index;
  logic [mmp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mmp_ram.sv =====
// ----------------------------------------------------------------------------
// mmp_ram
// generic simple dual-port ram, one write and one registered read
// ----------------------------------------------------------------------------
module mmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mmp_cell.sv =====
// ----------------------------------------------------------------------------
// mmp_cell
// one column cell: column storage, rotating row operand and modular mac
// ----------------------------------------------------------------------------
module mmp_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mmp_pkg::idx_t               cell_idx,
  input  mmp_pkg::cell_ctl_t          ctl,
  input  logic [mmp_pkg::VAL_W-1:0]   sh_right,
  input  logic [mmp_pkg::VAL_W-1:0]   sh_head,
  output logic [mmp_pkg::VAL_W-1:0]   sh_out,
  input  logic [mmp_pkg::VAL_W-1:0]   vec_right,
  output logic [mmp_pkg::VAL_W-1:0]   vec_out
);

  logic [mmp_pkg::VAL_W-1:0]    vstore_r, vec_r, vec_nxt, sh_r, sh_nxt, acc_r, acc_nxt;
  mmp_pkg::idx_t                k_r, k_nxt;
  logic [2*mmp_pkg::VAL_W-1:0]  m_r;
  logic [mmp_pkg::VAL_W+3:0]    f1_r, f1_nxt;
  logic                         v1_r, v2_r;
  logic [mmp_pkg::VAL_W-1:0]    q;
  logic [mmp_pkg::VAL_W:0]      fold_x, acc_sum;
  logic [mmp_pkg::VAL_W-1:0]    fold_r;
  logic                         we;
  logic [mmp_pkg::RAM_AW-1:0]   waddr, raddr;
  logic [mmp_pkg::VAL_W-1:0]    wdata;

  assign we    = (ctl.load_mat && ctl.ld_col == cell_idx) || ctl.wr_res;
  assign waddr = ctl.load_mat ? mmp_pkg::ram_addr(mmp_pkg::BANK_STORE, ctl.ld_row)
                              : mmp_pkg::ram_addr(ctl.wr_bank, ctl.row);
  assign wdata = ctl.load_mat ? ctl.ld_value : acc_r;
  assign raddr = mmp_pkg::ram_addr(ctl.rd_bank, ctl.rd_own ? k_r : ctl.row);

  mmp_ram #(
    .WIDTH (mmp_pkg::VAL_W),
    .DEPTH (mmp_pkg::RAM_DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  always_comb begin
    vec_nxt = vec_r;
    if (ctl.init_vec) begin
      vec_nxt = mmp_pkg::reduce_once({1'b0, vstore_r});
    end else if (ctl.wr_vec) begin
      vec_nxt = acc_r;
    end else if (ctl.shift_out) begin
      vec_nxt = vec_right;
    end

    sh_nxt = sh_r;
    if (ctl.load_sh) begin
      sh_nxt = ctl.sh_from_vec ? vec_r : q;
    end else if (ctl.rotate) begin
      // last active cell closes the ring
      sh_nxt = (cell_idx == ctl.d_last) ? sh_head : sh_right;
    end

    k_nxt = k_r;
    if (ctl.set_k) begin
      k_nxt = cell_idx;
    end else if (ctl.step_k) begin
      k_nxt = (k_r == ctl.d_last) ? '0 : k_r + 1'b1;
    end

    // first fold: hi * 15 + lo
    f1_nxt = (mmp_pkg::VAL_W+4)'(m_r[2*mmp_pkg::VAL_W-1:mmp_pkg::VAL_W])
             * (mmp_pkg::VAL_W+4)'(mmp_pkg::FOLD)
           + (mmp_pkg::VAL_W+4)'(m_r[mmp_pkg::VAL_W-1:0]);
    // second fold leaves a value below twice the modulus
    fold_x  = (mmp_pkg::VAL_W+1)'(f1_r[mmp_pkg::VAL_W+3:mmp_pkg::VAL_W])
              * (mmp_pkg::VAL_W+1)'(mmp_pkg::FOLD)
            + (mmp_pkg::VAL_W+1)'(f1_r[mmp_pkg::VAL_W-1:0]);
    fold_r  = mmp_pkg::reduce_once(fold_x);
    acc_sum = (mmp_pkg::VAL_W+1)'(acc_r) + (mmp_pkg::VAL_W+1)'(fold_r);

    acc_nxt = acc_r;
    if (ctl.clr_acc) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = mmp_pkg::reduce_once(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_vec && ctl.ld_row == cell_idx) begin
      vstore_r <= ctl.ld_value;
    end
    vec_r <= vec_nxt;
    sh_r  <= sh_nxt;
    k_r   <= k_nxt;
    m_r   <= (2*mmp_pkg::VAL_W)'(sh_r) * (2*mmp_pkg::VAL_W)'(q);
    f1_r  <= f1_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.mac_v;
      v2_r <= v1_r;
    end
  end

  assign sh_out  = sh_r;
  assign vec_out = vec_r;

endmodule

// ===== hw/rtl/mmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmp_ctrl
// sequencer for loads, square-and-multiply passes and result streaming
// ----------------------------------------------------------------------------
module mmp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  mmp_in_if.sink               in_req,
  mmp_cfg_if.sink              cfg_req,
  input  logic                 out_ready,
  output mmp_pkg::cell_ctl_t   ctl,
  output mmp_pkg::out_stat_t   stat
);

  mmp_pkg::state_t             state_r, state_nxt;
  logic [mmp_pkg::EXP_W-1:0]   exp_sh_r, exp_sh_nxt, exp_r;
  mmp_pkg::dim_t               dim_r, dim_act;
  mmp_pkg::bank_t              src_r, src_nxt, dst;
  logic                        op_vec_r, op_vec_nxt, mac_v_r;
  mmp_pkg::idx_t               row_r, row_nxt, t_r, t_nxt, out_idx_r, out_idx_nxt, d_last;
  logic [mmp_pkg::DRAIN_W-1:0] drain_r, drain_nxt;
  logic                        in_fire, cfg_fire, row_ok, col_ok;

  assign in_req.ready  = (state_r == mmp_pkg::ST_IDLE);
  assign cfg_req.ready = 1'b1;
  assign in_fire  = in_req.valid && in_req.ready;
  assign cfg_fire = cfg_req.valid && cfg_req.ready;
  assign row_ok   = {1'b0, in_req.row_index} < mmp_pkg::fidx_wide_t'(mmp_pkg::MAX_DIM);
  assign col_ok   = {1'b0, in_req.col_index} < mmp_pkg::fidx_wide_t'(mmp_pkg::MAX_DIM);

  always_comb begin
    if (dim_r == '0) begin
      dim_act = mmp_pkg::dim_t'(1);
    end else if (dim_r > mmp_pkg::dim_t'(mmp_pkg::DIM_LIMIT)) begin
      dim_act = mmp_pkg::dim_t'(mmp_pkg::DIM_LIMIT);
    end else begin
      dim_act = dim_r;
    end
  end
  assign d_last = mmp_pkg::IDX_W'(dim_act - 1'b1);
  assign dst    = (src_r == mmp_pkg::BANK_A) ? mmp_pkg::BANK_B : mmp_pkg::BANK_A;

  // next state
  always_comb begin
    state_nxt   = state_r;
    exp_sh_nxt  = exp_sh_r;
    src_nxt     = src_r;
    op_vec_nxt  = op_vec_r;
    row_nxt     = row_r;
    t_nxt       = t_r;
    drain_nxt   = drain_r;
    out_idx_nxt = out_idx_r;
    unique case (state_r)
      mmp_pkg::ST_IDLE: begin
        if (in_fire && in_req.opcode == mmp_pkg::OP_START) begin
          exp_sh_nxt = (exp_r == '0) ? mmp_pkg::EXP_W'(1) : exp_r;
          src_nxt    = mmp_pkg::BANK_STORE;
          state_nxt  = mmp_pkg::ST_DECIDE;
        end
      end
      mmp_pkg::ST_DECIDE: begin
        row_nxt = '0;
        if (exp_sh_r[0]) begin
          op_vec_nxt = 1'b1;
          state_nxt  = mmp_pkg::ST_LOAD;
        end else if (exp_sh_r[mmp_pkg::EXP_W-1:1] == '0) begin
          out_idx_nxt = '0;
          state_nxt   = mmp_pkg::ST_OUT;
        end else begin
          exp_sh_nxt = exp_sh_r >> 1;
          op_vec_nxt = 1'b0;
          state_nxt  = mmp_pkg::ST_LOAD;
        end
      end
      mmp_pkg::ST_LOAD: begin
        t_nxt     = '0;
        state_nxt = mmp_pkg::ST_RUN;
      end
      mmp_pkg::ST_RUN: begin
        t_nxt = t_r + 1'b1;
        if (t_r == d_last) begin
          drain_nxt = '0;
          state_nxt = mmp_pkg::ST_DRAIN;
        end
      end
      mmp_pkg::ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == mmp_pkg::DRAIN_LAST) begin
          state_nxt = mmp_pkg::ST_WRITE;
        end
      end
      mmp_pkg::ST_WRITE: begin
        if (op_vec_r) begin
          exp_sh_nxt[0] = 1'b0;
          state_nxt     = mmp_pkg::ST_DECIDE;
        end else if (row_r == d_last) begin
          src_nxt   = dst;
          state_nxt = mmp_pkg::ST_DECIDE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = mmp_pkg::ST_LOAD;
        end
      end
      mmp_pkg::ST_OUT: begin
        if (out_ready) begin
          if (out_idx_r == d_last) begin
            state_nxt = mmp_pkg::ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = mmp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.load_vec    = in_fire && in_req.opcode == mmp_pkg::OP_LOAD_VEC && row_ok;
    ctl.load_mat    = in_fire && in_req.opcode == mmp_pkg::OP_LOAD_MAT && row_ok && col_ok;
    ctl.ld_row      = mmp_pkg::IDX_W'(in_req.row_index);
    ctl.ld_col      = mmp_pkg::IDX_W'(in_req.col_index);
    ctl.ld_value    = in_req.value;
    ctl.init_vec    = in_fire && in_req.opcode == mmp_pkg::OP_START;
    ctl.rd_bank     = src_r;
    ctl.rd_own      = (state_r == mmp_pkg::ST_RUN);
    ctl.row         = row_r;
    ctl.set_k       = (state_r == mmp_pkg::ST_LOAD);
    ctl.step_k      = (state_r == mmp_pkg::ST_RUN);
    ctl.load_sh     = (state_r == mmp_pkg::ST_RUN) && (t_r == '0);
    ctl.sh_from_vec = op_vec_r;
    ctl.rotate      = mac_v_r;
    ctl.mac_v       = mac_v_r;
    ctl.clr_acc     = (state_r == mmp_pkg::ST_LOAD);
    ctl.wr_vec      = (state_r == mmp_pkg::ST_WRITE) && op_vec_r;
    ctl.wr_res      = (state_r == mmp_pkg::ST_WRITE) && !op_vec_r;
    ctl.wr_bank     = dst;
    ctl.d_last      = d_last;
    ctl.shift_out   = (state_r == mmp_pkg::ST_OUT) && out_ready;
    stat.valid      = (state_r == mmp_pkg::ST_OUT);
    stat.idx        = out_idx_r;
    stat.last       = (out_idx_r == d_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mmp_pkg::ST_IDLE;
      exp_sh_r <= '0;
      dim_r    <= mmp_pkg::dim_t'(1);
      exp_r    <= mmp_pkg::EXP_W'(1);
      src_r    <= mmp_pkg::BANK_STORE;
      op_vec_r <= 1'b0;
      mac_v_r  <= 1'b0;
      row_r    <= '0;
      t_r      <= '0;
      drain_r  <= '0;
      out_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      exp_sh_r  <= exp_sh_nxt;
      src_r     <= src_nxt;
      op_vec_r  <= op_vec_nxt;
      mac_v_r   <= (state_r == mmp_pkg::ST_RUN);
      row_r     <= row_nxt;
      t_r       <= t_nxt;
      drain_r   <= drain_nxt;
      out_idx_r <= out_idx_nxt;
      if (cfg_fire) begin
        unique case (cfg_req.index)
          mmp_pkg::CFG_DIMENSION: dim_r <= cfg_req.data[mmp_pkg::DIM_W-1:0];
          mmp_pkg::CFG_EXPONENT:  exp_r <= cfg_req.data[mmp_pkg::EXP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/mod_matrix_power.sv =====
// ----------------------------------------------------------------------------
// mod_matrix_power
// vector times matrix power modulo 65521 on a ring of column cells
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   accepted when
//  in_req    in   opcode, row_index, col_index, value       valid && ready
//  out_res   out  result_index, result_value, last          valid && ready
//  cfg_req   in   index (0 dimension, 1 exponent), data     valid && ready
//
//  load requests are taken while the block is idle; a start request occupies it:
//  per exponent step a vector pass for a set bit and, per squaring, a pass over
//  every matrix row, each pass rotating the row operand through the ring,
//  then d results, one per accepted request on out_res
//  rst_n is synchronous; matrix and vector stores are undefined until written
//  in_req.ready is low from a start request until the last result is taken;
//  a stalled out_res holds the current result; cfg_req is always ready
// ----------------------------------------------------------------------------
module mod_matrix_power (
  input  logic      clk,
  input  logic      rst_n,
  mmp_in_if.sink    in_req,
  mmp_out_if.source out_res,
  mmp_cfg_if.sink   cfg_req
);

  mmp_pkg::cell_ctl_t         ctl;
  mmp_pkg::out_stat_t         stat;
  logic [mmp_pkg::VAL_W-1:0]  sh_w  [mmp_pkg::MAX_DIM];
  logic [mmp_pkg::VAL_W-1:0]  vec_w [mmp_pkg::MAX_DIM];

  // sequencer: loads, square-and-multiply passes, result streaming
  mmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_req   (cfg_req),
    .out_ready (out_res.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  // cell j owns matrix column j in three banks (loaded, two squaring buffers)
  // and vector element j; the row operand rotates around the ring
  for (genvar j = 0; j < mmp_pkg::MAX_DIM; j++) begin : g_cell
    logic [mmp_pkg::VAL_W-1:0] sh_right, vec_right;
    if (j == mmp_pkg::MAX_DIM - 1) begin : g_end
      assign sh_right  = sh_w[0];
      assign vec_right = '0;
    end else begin : g_mid
      assign sh_right  = sh_w[j+1];
      assign vec_right = vec_w[j+1];
    end

    mmp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (mmp_pkg::IDX_W'(j)),
      .ctl       (ctl),
      .sh_right  (sh_right),
      .sh_head   (sh_w[0]),
      .sh_out    (sh_w[j]),
      .vec_right (vec_right),
      .vec_out   (vec_w[j])
    );
  end

  // results leave from cell 0 while the vector shifts down the row
  assign out_res.valid        = stat.valid;
  assign out_res.result_index = mmp_pkg::FIELD_IDX_W'(stat.idx);
  assign out_res.result_value = vec_w[0];
  assign out_res.last         = stat.last;

  // no input taken while results are pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !in_req.ready)
    else $error("input accepted while results pending");

  // the block returns to idle once the last result is taken
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready && out_res.last) |=> in_req.ready)
    else $error("block not idle after last result");

  // every emitted residue is reduced
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.result_value < 16'd65521))
    else $error("result not reduced modulo 65521");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for mod_matrix_power: loads vector and matrix, runs
// v * A^e mod 65521 under several dimension/exponent settings and compares
// every result element against a local square-and-multiply predictor
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [mmp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint unsigned PRIME = 65521;

  typedef logic [mmp_pkg::EXP_W-1:0] exp_val_t;

  typedef struct {
    logic [mmp_pkg::FIELD_IDX_W-1:0] idx;
    logic [mmp_pkg::VAL_W-1:0]       val;
    logic                            last;
  } elem_t;

  logic clk;
  logic rst_n;

  mmp_in_if  in_bus();
  mmp_out_if out_bus();
  mmp_cfg_if cfg_bus();

  mod_matrix_power i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_bus),
    .out_res(out_bus),
    .cfg_req(cfg_bus)
  );

  // predictor state: stored operands, write tracking and register shadows
  logic [mmp_pkg::VAL_W-1:0] vec_mem[mmp_pkg::MAX_DIM];
  logic [mmp_pkg::VAL_W-1:0] mat_mem[mmp_pkg::MAX_DIM][mmp_pkg::MAX_DIM];
  bit                        vec_set[mmp_pkg::MAX_DIM];
  bit                        mat_set[mmp_pkg::MAX_DIM][mmp_pkg::MAX_DIM];
  mmp_pkg::dim_t             dim_reg;
  exp_val_t                  exp_reg;

  elem_t result_fifo[$];
  int    fail_count;
  int    item_count;
  int    hold_left;     // receiver hold-off, counted down by the ready process
  bit    steady;        // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // clamp of the dimension register as the block applies it
  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > mmp_pkg::DIM_LIMIT) return mmp_pkg::DIM_LIMIT;
    return int'(dim_reg);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // v * A^e mod p, square-and-multiply on the shadow stores
  task automatic predict_power();
    int d;
    exp_val_t e;
    logic [mmp_pkg::VAL_W-1:0] sq[mmp_pkg::MAX_DIM][mmp_pkg::MAX_DIM];
    logic [mmp_pkg::VAL_W-1:0] nsq[mmp_pkg::MAX_DIM][mmp_pkg::MAX_DIM];
    logic [mmp_pkg::VAL_W-1:0] v[mmp_pkg::MAX_DIM];
    logic [mmp_pkg::VAL_W-1:0] nv[mmp_pkg::MAX_DIM];
    longint unsigned acc;
    elem_t el;
    d = active_dim();
    e = (exp_reg == '0) ? exp_val_t'(1) : exp_reg;
    for (int i = 0; i < d; i++) begin
      v[i] = mmp_pkg::VAL_W'(longint'(vec_mem[i]) % PRIME);
      for (int j = 0; j < d; j++) sq[i][j] = mat_mem[i][j];
    end
    while (e != 0) begin
      if (e[0]) begin
        for (int j = 0; j < d; j++) begin
          acc = 0;
          for (int i = 0; i < d; i++) acc += longint'(v[i]) * longint'(sq[i][j]);
          nv[j] = mmp_pkg::VAL_W'(acc % PRIME);
        end
        for (int j = 0; j < d; j++) v[j] = nv[j];
      end
      e = e >> 1;
      if (e != 0) begin
        for (int i = 0; i < d; i++)
          for (int j = 0; j < d; j++) begin
            acc = 0;
            for (int k = 0; k < d; k++) acc += longint'(sq[i][k]) * longint'(sq[k][j]);
            nsq[i][j] = mmp_pkg::VAL_W'(acc % PRIME);
          end
        for (int i = 0; i < d; i++)
          for (int j = 0; j < d; j++) sq[i][j] = nsq[i][j];
      end
    end
    for (int j = 0; j < d; j++) begin
      el.idx  = mmp_pkg::FIELD_IDX_W'(j);
      el.val  = v[j];
      el.last = (j == d - 1);
      result_fifo = {result_fifo, el};
    end
  endtask

  // one request on the input channel, prediction updated on acceptance
  task automatic send_request(logic [mmp_pkg::OP_W-1:0] op, int unsigned row,
                              int unsigned col, int unsigned val);
    int gap;
    logic [mmp_pkg::FIELD_IDX_W-1:0] r6;
    logic [mmp_pkg::FIELD_IDX_W-1:0] c6;
    logic [mmp_pkg::VAL_W-1:0]       v16;
    r6  = mmp_pkg::FIELD_IDX_W'(row);
    c6  = mmp_pkg::FIELD_IDX_W'(col);
    v16 = mmp_pkg::VAL_W'(val);
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= op;
    in_bus.row_index <= r6;
    in_bus.col_index <= c6;
    in_bus.value     <= v16;
    do @(posedge clk); while (!in_bus.ready);
    case (op)
      mmp_pkg::OP_LOAD_VEC: begin
        vec_mem[r6] = v16;
        vec_set[r6] = 1'b1;
      end
      mmp_pkg::OP_LOAD_MAT: begin
        mat_mem[r6][c6] = v16;
        mat_set[r6][c6] = 1'b1;
      end
      mmp_pkg::OP_START: predict_power();
      default: ;
    endcase
    if (op != OP_UNUSED) item_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // load every entry inside the active dimension not yet written
  task automatic fill_missing();
    int d;
    d = active_dim();
    for (int i = 0; i < d; i++) begin
      if (!vec_set[i]) send_request(mmp_pkg::OP_LOAD_VEC, i, $urandom, $urandom);
      for (int j = 0; j < d; j++)
        if (!mat_set[i][j]) send_request(mmp_pkg::OP_LOAD_MAT, i, j, $urandom);
    end
  endtask

  // drain all results, then let queued loads settle before touching registers
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    wait (result_fifo.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(mmp_pkg::cfg_reg_t idx, logic [mmp_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == mmp_pkg::CFG_DIMENSION) dim_reg = data[mmp_pkg::DIM_W-1:0];
    else exp_reg = data[mmp_pkg::EXP_W-1:0];
  endtask

  task automatic set_mode(mmp_pkg::dim_t d, exp_val_t e);
    wait_idle();
    cfg_write(mmp_pkg::CFG_DIMENSION, mmp_pkg::CFG_DATA_W'(d));
    cfg_write(mmp_pkg::CFG_EXPONENT, mmp_pkg::CFG_DATA_W'(e));
  endtask

  // reset values: dimension 1, exponent 1; stored values above the modulus
  task automatic test_reset_defaults();
    send_request(mmp_pkg::OP_LOAD_VEC, 0, 0, 65535);
    send_request(mmp_pkg::OP_LOAD_MAT, 0, 0, 65535);
    send_request(mmp_pkg::OP_START, 0, 0, 0);
    send_request(OP_UNUSED, 63, 63, 65535);
    send_request(mmp_pkg::OP_LOAD_MAT, 0, 0, 65520);
    send_request(mmp_pkg::OP_START, 63, 63, 65535);
  endtask

  // register extremes: zero dimension and exponent, largest exponent,
  // index 63 loads
  task automatic test_config_extremes();
    set_mode(mmp_pkg::dim_t'(0), exp_val_t'(0));
    send_request(mmp_pkg::OP_LOAD_VEC, 0, 0, 0);
    send_request(mmp_pkg::OP_START, 0, 0, 0);
    set_mode(mmp_pkg::dim_t'(2), '1);
    fill_missing();
    send_request(mmp_pkg::OP_START, 0, 0, 0);
    set_mode(mmp_pkg::dim_t'(5), exp_val_t'(2));
    send_request(mmp_pkg::OP_LOAD_VEC, 63, 0, 65520);
    send_request(mmp_pkg::OP_LOAD_MAT, 63, 63, 65520);
    fill_missing();
    send_request(mmp_pkg::OP_START, 0, 0, 0);
  endtask

  // receiver holds off long while the sender keeps offering, so the block
  // stalls its input; then the sender waits for a full drain
  task automatic test_backpressure();
    set_mode(mmp_pkg::dim_t'(3), exp_val_t'(5));
    fill_missing();
    hold_left = 400;
    send_request(mmp_pkg::OP_START, 0, 0, 0);
    for (int i = 0; i < 3; i++) send_request(mmp_pkg::OP_LOAD_VEC, i, 0, $urandom);
    send_request(mmp_pkg::OP_START, 0, 0, 0);
    wait_idle();
    send_request(mmp_pkg::OP_START, 0, 0, 0);
  endtask

  task automatic test_random_mix();
    int n;
    int d;
    mmp_pkg::dim_t dsel;
    exp_val_t esel;
    while (item_count < 500) begin
      case ($urandom_range(0, 9))
        0:       dsel = mmp_pkg::dim_t'($urandom_range(0, 127));
        1, 2:    dsel = mmp_pkg::dim_t'($urandom_range(7, 10));
        default: dsel = mmp_pkg::dim_t'($urandom_range(1, 6));
      endcase
      if (dsel == 0 || dsel > 12) dsel = mmp_pkg::dim_t'($urandom_range(1, 4));
      if ($urandom_range(0, 2) == 0) esel = exp_val_t'({$urandom, $urandom});
      else esel = exp_val_t'($urandom_range(0, 40));
      set_mode(dsel, esel);
      d = active_dim();
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(0, 12);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0: send_request(OP_UNUSED, $urandom, $urandom, $urandom);
            1: send_request(mmp_pkg::OP_LOAD_MAT, $urandom, $urandom, $urandom);
            2, 3, 4: send_request(mmp_pkg::OP_LOAD_VEC, $urandom_range(0, d - 1),
                                  $urandom, $urandom);
            default: send_request(mmp_pkg::OP_LOAD_MAT, $urandom_range(0, d - 1),
                                  $urandom_range(0, d - 1), $urandom);
          endcase
        end
        fill_missing();
        send_request(mmp_pkg::OP_START, $urandom, $urandom, $urandom);
      end
      steady = 1'b0;
    end
  endtask

  // receiver ready: random stalls, long hold-offs on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 199) == 0) hold_left = $urandom_range(20, 80);
      end
    end
  end

  // result checker against the oldest expected element
  always @(posedge clk) begin
    elem_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (result_fifo.size() == 0) begin
        $display("%0t: unexpected result idx %0d value %0d last %0b", $time,
                 out_bus.result_index, out_bus.result_value, out_bus.last);
        fail_count++;
      end else begin
        want = result_fifo.pop_front();
        if (out_bus.result_index !== want.idx || out_bus.result_value !== want.val ||
            out_bus.last !== want.last) begin
          $display("%0t: mismatch expected idx %0d value %0d last %0b, got idx %0d value %0d last %0b",
                   $time, want.idx, want.val, want.last,
                   out_bus.result_index, out_bus.result_value, out_bus.last);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = mmp_pkg::OP_LOAD_VEC;
    in_bus.row_index = '0;
    in_bus.col_index = '0;
    in_bus.value     = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = mmp_pkg::CFG_DIMENSION;
    cfg_bus.data     = '0;
    fail_count = 0;
    item_count = 0;
    hold_left  = 0;
    steady     = 1'b0;
    dim_reg    = mmp_pkg::dim_t'(1);
    exp_reg    = exp_val_t'(1);
    for (int i = 0; i < mmp_pkg::MAX_DIM; i++) begin
      vec_set[i] = 1'b0;
      for (int j = 0; j < mmp_pkg::MAX_DIM; j++) mat_set[i][j] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random_mix();

    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && result_fifo.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
